/* sv/rlb_pkg.sv */
// Shared types and constants for the RGB layer blend pipeline.
`default_nettype none

package rlb_pkg;

  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned NUM_STAGES = 4;

  // round(n/255) is computed as floor((n + 127) * 32897 / 2^23). This is exact while
  // (n + 127) stays below 66052, which covers every product the blend modes form.
  localparam logic [17:0] DIV_BIAS    = 18'd127;
  localparam logic [31:0] RECIP_255   = 32'd32897;
  localparam int unsigned RECIP_SHIFT = 23;

  typedef enum logic [1:0] {
    MODE_MULTIPLY = 2'd0,
    MODE_SUBTRACT = 2'd1,
    MODE_SCREEN   = 2'd2,
    MODE_OVERLAY  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_INVERT,
    KIND_SUB
  } kind_e;

endpackage

`default_nettype wire

/* sv/rlb_chan.sv */
// Four-stage datapath that blends one color channel of a top and a bottom pixel.
`default_nettype none

module rlb_chan (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  rlb_pkg::mode_e           mode_i,
  input  logic [rlb_pkg::CHAN_W-1:0] top_i,
  input  logic [rlb_pkg::CHAN_W-1:0] bottom_i,
  output logic [rlb_pkg::CHAN_W-1:0] out_o
);
  import rlb_pkg::*;

  // Stage 1: operand selection.
  logic [CHAN_W:0]   x_d, x_q;
  logic [CHAN_W-1:0] y_d, y_q;
  kind_e             kind1_d, kind1_q;
  logic [CHAN_W-1:0] sub_d, sub1_q;

  // Stage 2: product.
  logic [16:0]       p_q;
  kind_e             kind2_q;
  logic [CHAN_W-1:0] sub2_q;

  // Stage 3: rounded quotient.
  logic [17:0]       n;
  logic [31:0]       recip_prod;
  logic [CHAN_W-1:0] quo_q;
  kind_e             kind3_q;
  logic [CHAN_W-1:0] sub3_q;

  // Stage 4: output.
  logic [CHAN_W-1:0] res_d, res_q;

  always_comb begin
    x_d     = '0;
    y_d     = '0;
    kind1_d = KIND_DIRECT;
    sub_d   = (bottom_i > top_i) ? (bottom_i - top_i) : '0;
    unique case (mode_i)
      MODE_MULTIPLY: begin
        x_d     = {1'b0, top_i};
        y_d     = bottom_i;
        kind1_d = KIND_DIRECT;
      end
      MODE_SUBTRACT: begin
        kind1_d = KIND_SUB;
      end
      MODE_SCREEN: begin
        x_d     = {1'b0, ~top_i};
        y_d     = ~bottom_i;
        kind1_d = KIND_INVERT;
      end
      MODE_OVERLAY: begin
        // The dark half doubles the multiply; the light half doubles the screen term.
        if (!bottom_i[CHAN_W-1]) begin
          x_d     = {top_i, 1'b0};
          y_d     = bottom_i;
          kind1_d = KIND_DIRECT;
        end else begin
          x_d     = {~top_i, 1'b0};
          y_d     = ~bottom_i;
          kind1_d = KIND_INVERT;
        end
      end
      default: begin
        kind1_d = KIND_DIRECT;
      end
    endcase
  end

  assign n          = {1'b0, p_q} + DIV_BIAS;
  assign recip_prod = {14'd0, n} * RECIP_255;

  always_comb begin
    case (kind3_q)
      KIND_DIRECT: res_d = quo_q;
      KIND_INVERT: res_d = ~quo_q;
      KIND_SUB:    res_d = sub3_q;
      default:     res_d = quo_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q     <= x_d;
      y_q     <= y_d;
      kind1_q <= kind1_d;
      sub1_q  <= sub_d;

      p_q     <= {8'd0, x_q} * {9'd0, y_q};
      kind2_q <= kind1_q;
      sub2_q  <= sub1_q;

      quo_q   <= recip_prod[RECIP_SHIFT+CHAN_W-1:RECIP_SHIFT];
      kind3_q <= kind2_q;
      sub3_q  <= sub2_q;

      res_q   <= res_d;
    end
  end

  assign out_o = res_q;

endmodule

`default_nettype wire

/* sv/rgb_layer_blend.sv */
// Top level of the RGB layer blend: stream ports, mode register and pipeline control.
`default_nettype none

// Blends a top and a bottom 8-bit BGR pixel per request, with multiply, subtract,
// screen or overlay chosen by the 2-bit mode register (cfg_we_i/cfg_wdata_i, reset
// to multiply). The block takes one pixel pair every clock while the output is not
// stalled. A result passes through the four pipeline stages: operand selection,
// a 9x8 product, a reciprocal multiply that divides by 255 with rounding, and the
// final select into the output register. When a result waits on a stalled output
// the whole pipeline holds. Write the mode only while idle.
module rgb_layer_blend (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // top_blue, top_green, top_red, bottom_blue, bottom_green, bottom_red
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_blue, out_green, out_red
  output logic [23:0] m_axis_tdata
);
  import rlb_pkg::*;

  mode_e                 mode_d, mode_q;
  logic [NUM_STAGES-1:0] valid_d, valid_q;
  logic                  en;

  assign en            = !valid_q[NUM_STAGES-1] || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];

  assign mode_d  = cfg_we_i ? mode_e'(cfg_wdata_i) : mode_q;
  assign valid_d = en ? {valid_q[NUM_STAGES-2:0], s_axis_tvalid} : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_MULTIPLY;
      valid_q <= '0;
    end else begin
      mode_q  <= mode_d;
      valid_q <= valid_d;
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_chan
    rlb_chan u_chan (
      .clk_i    (clk_i),
      .en_i     (en),
      .mode_i   (mode_q),
      .top_i    (s_axis_tdata[c*CHAN_W +: CHAN_W]),
      .bottom_i (s_axis_tdata[(c+NUM_CHAN)*CHAN_W +: CHAN_W]),
      .out_o    (m_axis_tdata[c*CHAN_W +: CHAN_W])
    );
  end

`ifndef ASSERT_OFF
  // Input is refused only when a finished result is waiting on the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output backpressure");

  // An advancing pipeline moves each valid bit one stage forward.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (valid_q[NUM_STAGES-1:1] == $past(valid_q[NUM_STAGES-2:0])))
    else $error("valid bits did not shift with the pipeline");

  // A stalled pipeline keeps every valid bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_q))
    else $error("valid bits changed during a stall");

  // An accepted request is captured in the first pipeline stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> valid_q[0])
    else $error("accepted request was not captured");
`endif

endmodule

`default_nettype wire
